FILE: hdl/broadcast_ring_multi_reader_macros.svh
// ----------------------------------------------------------------------------
// Broadcast ring assertion macros
// Shared concurrent assertion shorthands for the broadcast ring checker.
// ----------------------------------------------------------------------------
`ifndef BROADCAST_RING_MULTI_READER_MACROS_SVH
`define BROADCAST_RING_MULTI_READER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define BRMR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define BRMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/brmr_pkg.sv
// ----------------------------------------------------------------------------
// Broadcast ring package
// Request and response types, operation codes and controller states for the
// single-writer, multi-reader broadcast ring.
// ----------------------------------------------------------------------------
`default_nettype none

package brmr_pkg;

   // Fixed field widths of the request and response.
   localparam int MODE_W      = 2;
   localparam int READER_W    = 3;
   localparam int PAYLOAD_W   = 32;
   localparam int COUNT_W     = 32;
   localparam int READERCNT_W = 4;

   // Number of reader slots that the reader field can address.
   localparam int READER_SLOTS = 8;

   // Operation codes carried in the mode field.
   localparam logic [MODE_W-1:0] MODE_PUBLISH   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ      = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SUBSCRIBE = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]    mode;
      logic [READER_W-1:0]  reader;
      logic [PAYLOAD_W-1:0] payload_in;
   } req_type;

   typedef struct packed {
      logic                   message_valid;
      logic [PAYLOAD_W-1:0]   payload_out;
      logic [READERCNT_W-1:0] reader_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_RESPOND
   } state_type;

endpackage

`default_nettype wire

FILE: hdl/broadcast_ring_multi_reader.sv
// ----------------------------------------------------------------------------
// Broadcast ring with one writer and several readers
// A request passes through the lookup and respond states before its response
// is registered. No new request is taken until the counter memory read, the
// ring memory read and the response register load of the last one are done
// in turn. Reset clears the write count, the subscription bits and the
// response slot; the ring and counter memories need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module broadcast_ring_multi_reader #(
   parameter int RING_DEPTH   = 8,
   parameter int READERS      = 8,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire brmr_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output brmr_pkg::rsp_type      rsp_data
);

   // Derived sizes. Only the first READER_SLOTS readers can be addressed.
   localparam int NUM_RD = (READERS < brmr_pkg::READER_SLOTS) ?
                           READERS : brmr_pkg::READER_SLOTS;
   localparam int RD_AW  = (NUM_RD > 1) ? $clog2(NUM_RD) : 1;
   localparam int RG_AW  = $clog2(RING_DEPTH);
   localparam int STORE_BITS = (PAYLOAD_BITS < brmr_pkg::PAYLOAD_W) ?
                               PAYLOAD_BITS : brmr_pkg::PAYLOAD_W;
   localparam int CNT_W  = brmr_pkg::COUNT_W + RG_AW;

   // Residue of 2^32 modulo the depth, used when a skip target wraps below zero.
   localparam longint WRAP_REM_L = 64'h1_0000_0000 % RING_DEPTH;
   localparam logic [RG_AW:0]   WRAP_REM = (RG_AW+1)'(WRAP_REM_L);
   localparam logic [RG_AW:0]   DEPTH_X  = (RG_AW+1)'(RING_DEPTH);
   localparam logic [RG_AW-1:0] LAST_IDX = RG_AW'(RING_DEPTH - 1);
   localparam logic [brmr_pkg::COUNT_W-1:0] DEPTH_W = brmr_pkg::COUNT_W'(RING_DEPTH);
   localparam logic [brmr_pkg::READER_W:0]  NUM_RD_X = (brmr_pkg::READER_W+1)'(NUM_RD);

   // Controller state and handshake controls.
   brmr_pkg::state_type state_ff, state_in;
   logic accept;
   logic lookup_en;
   logic load_rsp;

   // Held request and write side state.
   brmr_pkg::req_type               req_hold_ff;
   logic [brmr_pkg::COUNT_W-1:0]    wc_ff, wc_in;
   logic [RG_AW-1:0]                widx_ff, widx_in;
   logic [NUM_RD-1:0]               present_ff, present_in;

   // Memories and their registered read data.
   logic [STORE_BITS-1:0] ring_mem [RING_DEPTH];
   logic [STORE_BITS-1:0] ring_q_ff;
   logic [CNT_W-1:0]      cnt_mem [NUM_RD];
   logic [CNT_W-1:0]      cnt_q_ff;

   // Result fields carried from the lookup step to the response step.
   logic                               msg_ff, msg_in;
   logic [brmr_pkg::READERCNT_W-1:0]   count_ff, count_in;

   // Response slot.
   logic              rsp_valid_ff, rsp_valid_in;
   brmr_pkg::rsp_type rsp_data_ff,  rsp_data_in;

   // Lookup datapath.
   logic                         is_pub, is_read, is_sub, r_ok, read_hit, skip;
   logic [RD_AW-1:0]             rd_sel;
   logic [brmr_pkg::COUNT_W-1:0] rc, lag, rc_eff, rc_next;
   logic [RG_AW-1:0]             ridx, idx_eff, idx_next, skip_idx;
   logic [RG_AW:0]               skip_sum, skip_diff;
   logic                         cnt_we, ring_we;
   logic [CNT_W-1:0]             cnt_wdata;

   // Next state of the controller.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brmr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = brmr_pkg::ST_LOOKUP;
            end
         end
         brmr_pkg::ST_LOOKUP: begin
            state_in = brmr_pkg::ST_RESPOND;
         end
         brmr_pkg::ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = brmr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brmr_pkg::ST_IDLE;
         end
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_stall = 1'b1;
      lookup_en = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         brmr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         brmr_pkg::ST_LOOKUP: begin
            lookup_en = 1'b1;
         end
         brmr_pkg::ST_RESPOND: begin
            load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   // Decode of the held request.
   always_comb begin
      is_pub  = (req_hold_ff.mode == brmr_pkg::MODE_PUBLISH);
      is_read = (req_hold_ff.mode == brmr_pkg::MODE_READ);
      is_sub  = (req_hold_ff.mode == brmr_pkg::MODE_SUBSCRIBE);
      r_ok    = ({1'b0, req_hold_ff.reader} < NUM_RD_X);
      rd_sel  = req_hold_ff.reader[RD_AW-1:0];
   end

   // Read pointer update: lag check, skip to the oldest kept entry, advance.
   always_comb begin
      rc   = cnt_q_ff[CNT_W-1 -: brmr_pkg::COUNT_W];
      ridx = cnt_q_ff[RG_AW-1:0];
      lag  = wc_ff - rc;
      skip = (lag > DEPTH_W);

      // The ring slot of the write count minus the depth, also across wrap.
      skip_sum  = {1'b0, widx_ff} + WRAP_REM;
      skip_diff = skip_sum - DEPTH_X;
      if (wc_ff >= DEPTH_W) begin
         skip_idx = widx_ff;
      end else if (skip_sum >= DEPTH_X) begin
         skip_idx = skip_diff[RG_AW-1:0];
      end else begin
         skip_idx = skip_sum[RG_AW-1:0];
      end

      rc_eff  = skip ? (wc_ff - DEPTH_W) : rc;
      idx_eff = skip ? skip_idx : ridx;
      rc_next = rc_eff + 1'b1;
      if ((rc_next == '0) || (idx_eff == LAST_IDX)) begin
         idx_next = '0;
      end else begin
         idx_next = idx_eff + 1'b1;
      end

      read_hit = is_read && r_ok && present_ff[rd_sel] && (lag != '0);
   end

   // Write side, subscription and result updates made in the lookup step.
   always_comb begin
      wc_in      = wc_ff;
      widx_in    = widx_ff;
      present_in = present_ff;
      msg_in     = msg_ff;
      count_in   = count_ff;
      ring_we    = lookup_en && is_pub;
      cnt_we     = lookup_en && (read_hit || (is_sub && r_ok));
      cnt_wdata  = is_sub ? {wc_ff, widx_ff} : {rc_next, idx_next};
      if (lookup_en) begin
         msg_in   = read_hit;
         count_in = is_pub ? brmr_pkg::READERCNT_W'($countones(present_ff)) : '0;
         if (is_pub) begin
            wc_in = wc_ff + 1'b1;
            if ((wc_in == '0) || (widx_ff == LAST_IDX)) begin
               widx_in = '0;
            end else begin
               widx_in = widx_ff + 1'b1;
            end
         end
         if (is_sub && r_ok) begin
            present_in[rd_sel] = 1'b1;
         end
      end
   end

   // Response slot: loaded when free or being emptied.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.message_valid = msg_ff;
         rsp_data_in.payload_out   = msg_ff ? brmr_pkg::PAYLOAD_W'(ring_q_ff) : '0;
         rsp_data_in.reader_count  = count_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brmr_pkg::ST_IDLE;
         wc_ff        <= '0;
         widx_ff      <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wc_ff        <= wc_in;
         widx_ff      <= widx_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_hold_ff <= req_data;
      end
      msg_ff      <= msg_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Per-reader counter memory: read on accept, written back in the lookup step.
   always_ff @(posedge clock) begin
      if (accept) begin
         cnt_q_ff <= cnt_mem[req_data.reader[RD_AW-1:0]];
      end
      if (cnt_we) begin
         cnt_mem[rd_sel] <= cnt_wdata;
      end
   end

   // Ring memory: publish writes at the write slot, a read fetches its entry.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[widx_ff] <= req_hold_ff.payload_in[STORE_BITS-1:0];
      end
      if (lookup_en && is_read) begin
         ring_q_ff <= ring_mem[idx_eff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hdl/brmr_checker.sv
// ----------------------------------------------------------------------------
// Broadcast ring port checker
// Watches the request and response ports of the broadcast ring over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "broadcast_ring_multi_reader_macros.svh"

module brmr_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire brmr_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire brmr_pkg::rsp_type rsp_data
);

   // A stalled response keeps its payload.
   `BRMR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data), "response changed while stalled")

   // Requests are handled one at a time, so an accepted request closes the input.
   `BRMR_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall, "request accepted while another is in progress")

   // A fresh response only appears while a request is being worked on.
   `BRMR_ASSERT_SAME(a_rsp_from_req, clock, reset, $rose(rsp_valid), $past(req_stall), "response appeared without a request in progress")

   // A returned message never carries a reader count.
   `BRMR_ASSERT_SAME(a_msg_no_count, clock, reset, rsp_valid && rsp_data.message_valid, rsp_data.reader_count == '0, "message carries a reader count")

endmodule

bind broadcast_ring_multi_reader brmr_checker u_brmr_checker (.*);

`default_nettype wire
